[rtl/core/sound_channel_allocator_top_macros.svh]
// Assertion macros shared by the sound channel allocator RTL.
`ifndef SOUND_CHANNEL_ALLOCATOR_TOP_MACROS_SVH
`define SOUND_CHANNEL_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define SCA_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("sound channel allocator assertion failed");
// Check that a condition never holds outside reset.
`define SCA_NEVER(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error("sound channel allocator forbidden condition seen");
`else
`define SCA_ASSERT(lbl, clk_s, rstn_s, prop)
`define SCA_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

[rtl/core/sca_pkg.sv]
// Shared types, constants and helpers of the sound channel allocator.
package sca_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int CH_LIMIT         = 16;
    localparam int IDX_W            = 4;
    localparam logic [15:0] NO_SOURCE = 16'hFFFF;
    localparam int FRONT_DEPTH      = 2;
    localparam int RESULT_DEPTH     = 4;
    localparam logic [3:0] CHANNELS_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_STOP_SRC = 2'd1,
        CMD_STOP_SEC = 2'd2,
        CMD_FREE     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_REJECT   = 3'd0,
        OP_START    = 3'd1,
        OP_STOP_SRC = 3'd2,
        OP_STOP_SEC = 3'd3,
        OP_FREE     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        EV_STOPPED    = 2'd0,
        EV_GRANTED    = 2'd1,
        EV_NO_CHANNEL = 2'd2,
        EV_DONE       = 2'd3
    } event_t;

    typedef enum logic {
        CFG_CHANNELS_IN_USE = 1'b0,
        CFG_SOUND_ENABLED   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0] channels_in_use;
        logic       sound_enabled;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  sound_id;
        logic [7:0]  prio;
        logic        has_src;
        logic [15:0] src;
        logic        has_sec;
        logic [14:0] sec;
        logic [2:0]  sel;
    } req_t;

    typedef struct packed {
        event_t     ev;
        logic [2:0] chan;
        logic       last;
    } res_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } hit_t;

    // Find the lowest set bit of a channel mask.
    function automatic hit_t first_set(input logic [CH_LIMIT-1:0] mask);
        hit_t h;
        h.found = 1'b0;
        h.idx   = '0;
        for (int i = CH_LIMIT - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                h.found = 1'b1;
                h.idx   = IDX_W'(i);
            end
        end
        return h;
    endfunction

endpackage

[rtl/core/sca_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
module sca_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         cmd,
    input  logic [7:0]         sound_id,
    input  logic [7:0]         sound_priority,
    input  logic               source_valid,
    input  logic [15:0]        source_ref,
    input  logic               sector_valid,
    input  logic [14:0]        sector_num,
    input  logic [2:0]         channel_sel,
    input  logic               sound_enabled,
    output logic               req_valid,
    output sca_pkg::req_t      req,
    input  logic               req_pop
);

    localparam int DEPTH = sca_pkg::FRONT_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    sca_pkg::req_t q_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    sca_pkg::req_t dec;
    logic          do_push;
    logic          do_pop;

    // Classify the incoming beat
    always_comb
    begin
        dec.sound_id = sound_id;
        dec.prio     = sound_priority;
        dec.has_src  = source_valid && (source_ref != sca_pkg::NO_SOURCE);
        dec.src      = source_ref;
        dec.has_sec  = sector_valid;
        dec.sec      = sector_num;
        dec.sel      = channel_sel;
        case (sca_pkg::cmd_t'(cmd))
            sca_pkg::CMD_START:
            begin
                if (!sound_enabled || (sound_id == 8'd0))
                    dec.op = sca_pkg::OP_REJECT;
                else
                    dec.op = sca_pkg::OP_START;
            end
            sca_pkg::CMD_STOP_SRC: dec.op = sca_pkg::OP_STOP_SRC;
            sca_pkg::CMD_STOP_SEC: dec.op = sca_pkg::OP_STOP_SEC;
            sca_pkg::CMD_FREE:     dec.op = sca_pkg::OP_FREE;
            default:               dec.op = sca_pkg::OP_REJECT;
        endcase
    end

    assign full      = (count_reg == CW'(DEPTH));
    assign req_valid = (count_reg != '0);
    assign req       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_pop && req_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified request
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= dec;
    end

endmodule

[rtl/core/sca_outq.sv]
// Result queue between the back end and the result ports.
module sca_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_push,
    input  sca_pkg::res_t res_in,
    output logic          res_full,
    output logic          empty,
    input  logic          pop,
    output sca_pkg::res_t res_out
);

    localparam int DEPTH = sca_pkg::RESULT_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    sca_pkg::res_t q_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign res_full = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign res_out  = q_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the result beat
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= res_in;
    end

endmodule

[rtl/core/sca_back.sv]
// Back end: channel table and the sequencer that runs stop, allocate and steal scans.
`include "sound_channel_allocator_top_macros.svh"

module sca_back #(
    parameter int MAX_CHANNELS = sca_pkg::MAX_CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sca_pkg::cfg_t cfg,
    input  logic          req_valid,
    input  sca_pkg::req_t req,
    output logic          req_pop,
    input  logic          res_full,
    output logic          res_push,
    output sca_pkg::res_t res
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LIM  = sca_pkg::CH_LIMIT;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CMD   = 6'b000010,
        ST_STOP1 = 6'b000100,
        ST_ALLOC = 6'b001000,
        ST_STEAL = 6'b010000,
        ST_GRANT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    sca_pkg::req_t     req_reg, req_next;
    logic [CH_W-1:0]   chan_reg, chan_next;

    logic [7:0]  slot_sound_reg  [MAX_CHANNELS];
    logic [7:0]  slot_sound_next [MAX_CHANNELS];
    logic [7:0]  slot_prio_reg   [MAX_CHANNELS];
    logic [7:0]  slot_prio_next  [MAX_CHANNELS];
    logic [15:0] slot_source_reg [MAX_CHANNELS];
    logic [15:0] slot_source_next[MAX_CHANNELS];
    logic        slot_secv_reg   [MAX_CHANNELS];
    logic        slot_secv_next  [MAX_CHANNELS];
    logic [14:0] slot_sector_reg [MAX_CHANNELS];
    logic [14:0] slot_sector_next[MAX_CHANNELS];

    logic [4:0]              cnt;
    logic [MAX_CHANNELS-1:0] active;
    logic [MAX_CHANNELS-1:0] src_hit;
    logic [MAX_CHANNELS-1:0] sec_hit;
    logic [MAX_CHANNELS-1:0] free_hit;
    logic [MAX_CHANNELS-1:0] alloc_hit;
    logic [MAX_CHANNELS-1:0] steal_hit;
    logic [MAX_CHANNELS-1:0] scan_mask;
    sca_pkg::hit_t           hit;
    logic [CH_W-1:0]         hit_idx;
    logic                    clr_en;
    logic                    wr_en;

    // Clamp the channel count to the table size
    always_comb
    begin
        if (cfg.channels_in_use == 4'd0)
            cnt = 5'd1;
        else if ({1'b0, cfg.channels_in_use} > 5'(MAX_CHANNELS))
            cnt = 5'(MAX_CHANNELS);
        else
            cnt = {1'b0, cfg.channels_in_use};
    end

    // Compare every channel against the current request
    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            active[i]    = (slot_sound_reg[i] != 8'd0) && (5'(i) < cnt);
            src_hit[i]   = active[i] && (slot_source_reg[i] == req_reg.src);
            sec_hit[i]   = active[i] && slot_secv_reg[i]
                           && (slot_sector_reg[i] == req_reg.sec);
            free_hit[i]  = active[i] && (5'(req_reg.sel) == 5'(i));
            alloc_hit[i] = (5'(i) < cnt) && (!active[i]
                           || (req_reg.has_src && (slot_source_reg[i] == req_reg.src)));
            steal_hit[i] = (5'(i) < cnt) && (slot_prio_reg[i] >= req_reg.prio);
        end
    end

    // Pick the mask that the current step scans
    always_comb
    begin
        scan_mask = '0;
        case (state_reg)
            ST_CMD:
            begin
                case (req_reg.op)
                    sca_pkg::OP_STOP_SRC: scan_mask = req_reg.has_src ? src_hit : '0;
                    sca_pkg::OP_STOP_SEC: scan_mask = req_reg.has_sec ? sec_hit : '0;
                    sca_pkg::OP_FREE:     scan_mask = free_hit;
                    default:              scan_mask = '0;
                endcase
            end
            ST_STOP1:
            begin
                if (req_reg.has_sec)
                    scan_mask = sec_hit;
                else if (req_reg.has_src)
                    scan_mask = src_hit;
            end
            ST_ALLOC: scan_mask = alloc_hit;
            ST_STEAL: scan_mask = steal_hit;
            default:  scan_mask = '0;
        endcase
    end

    assign hit     = sca_pkg::first_set(LIM'(scan_mask));
    assign hit_idx = hit.idx[CH_W-1:0];

    // Sequence one step per cycle while the result queue has room, at most one result beat per step
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        chan_next  = chan_reg;
        req_pop    = 1'b0;
        res_push   = 1'b0;
        res.ev     = sca_pkg::EV_DONE;
        res.chan   = 3'd0;
        res.last   = 1'b1;
        clr_en     = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_pop    = 1'b1;
                    req_next   = req;
                    state_next = (req.op == sca_pkg::OP_START) ? ST_STOP1 : ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                    if (req_reg.op == sca_pkg::OP_REJECT)
                    begin
                        res.ev = sca_pkg::EV_NO_CHANNEL;
                    end
                    else if (hit.found)
                    begin
                        clr_en   = 1'b1;
                        res.ev   = sca_pkg::EV_STOPPED;
                        res.chan = 3'(hit_idx);
                    end
                end
            end
            ST_STOP1:
            begin
                if (!res_full)
                begin
                    state_next = ST_ALLOC;
                    if (hit.found)
                    begin
                        clr_en   = 1'b1;
                        res_push = 1'b1;
                        res.ev   = sca_pkg::EV_STOPPED;
                        res.chan = 3'(hit_idx);
                        res.last = 1'b0;
                    end
                end
            end
            ST_ALLOC:
            begin
                if (!res_full)
                begin
                    if (hit.found)
                    begin
                        chan_next  = hit_idx;
                        state_next = ST_GRANT;
                        // Take over the channel of the same source
                        if (active[hit_idx])
                        begin
                            clr_en   = 1'b1;
                            res_push = 1'b1;
                            res.ev   = sca_pkg::EV_STOPPED;
                            res.chan = 3'(hit_idx);
                            res.last = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next = ST_STEAL;
                    end
                end
            end
            ST_STEAL:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (hit.found)
                    begin
                        clr_en     = 1'b1;
                        chan_next  = hit_idx;
                        res.ev     = sca_pkg::EV_STOPPED;
                        res.chan   = 3'(hit_idx);
                        res.last   = 1'b0;
                        state_next = ST_GRANT;
                    end
                    else
                    begin
                        res.ev     = sca_pkg::EV_NO_CHANNEL;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_GRANT:
            begin
                if (!res_full)
                begin
                    wr_en      = 1'b1;
                    res_push   = 1'b1;
                    res.ev     = sca_pkg::EV_GRANTED;
                    res.chan   = 3'(chan_reg);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Update the channel table: clear on stop, fill on grant
    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            slot_sound_next[i]  = slot_sound_reg[i];
            slot_prio_next[i]   = slot_prio_reg[i];
            slot_source_next[i] = slot_source_reg[i];
            slot_secv_next[i]   = slot_secv_reg[i];
            slot_sector_next[i] = slot_sector_reg[i];
            if (clr_en && (hit_idx == CH_W'(i)))
                slot_sound_next[i] = 8'd0;
            if (wr_en && (chan_reg == CH_W'(i)))
            begin
                slot_sound_next[i]  = req_reg.sound_id;
                slot_prio_next[i]   = req_reg.prio;
                slot_source_next[i] = req_reg.has_src ? req_reg.src : sca_pkg::NO_SOURCE;
                slot_secv_next[i]   = req_reg.has_sec;
                slot_sector_next[i] = req_reg.has_sec ? req_reg.sec : 15'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < MAX_CHANNELS; i++)
                slot_sound_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            for (int i = 0; i < MAX_CHANNELS; i++)
                slot_sound_reg[i] <= slot_sound_next[i];
        end
    end

    // Hold request and payload fields; they are read only behind a live sound id
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        chan_reg <= chan_next;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            slot_prio_reg[i]   <= slot_prio_next[i];
            slot_source_reg[i] <= slot_source_next[i];
            slot_secv_reg[i]   <= slot_secv_next[i];
            slot_sector_reg[i] <= slot_sector_next[i];
        end
    end

    `SCA_NEVER(a_push_into_full, clk, rst_n, res_push && res_full)
    `SCA_ASSERT(a_grant_fills_slot, clk, rst_n, (res_push && (res.ev == sca_pkg::EV_GRANTED)) |=> (slot_sound_reg[$past(chan_reg)] != 8'd0))
    `SCA_ASSERT(a_stop_clears_slot, clk, rst_n, clr_en |=> (slot_sound_reg[$past(hit_idx)] == 8'd0))
    `SCA_ASSERT(a_last_ends_request, clk, rst_n, (res_push && res.last) |=> (state_reg == ST_IDLE))

endmodule

[rtl/core/sound_channel_allocator_top.sv]
// Top level of the sound channel allocator: ports, configuration registers, wiring.
// A request queued on push is taken by the idle back-end sequencer once it reaches
// the head of the request queue; while the result queue is not full, the sequencer
// runs one scan step per cycle and writes at most one result beat per cycle into
// a four-deep result queue. Stop, free and rejected requests go through pickup and
// one command step; a start runs pickup, stop scan, allocate scan, steal scan only
// if no channel is free, and grant, ending at the steal scan if nothing can be
// stolen. The channel table is in flip-flops, with sound ids cleared by reset.
module sound_channel_allocator_top #(
    parameter int MAX_CHANNELS = sca_pkg::MAX_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [7:0]  sound_id,
    input  logic [7:0]  sound_priority,
    input  logic        source_valid,
    input  logic [15:0] source_ref,
    input  logic        sector_valid,
    input  logic [14:0] sector_num,
    input  logic [2:0]  channel_sel,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  event_res,
    output logic [2:0]  channel_out,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    sca_pkg::cfg_t cfg_reg, cfg_next;
    sca_pkg::req_t req;
    sca_pkg::res_t res_in;
    sca_pkg::res_t res_out;
    logic          req_valid;
    logic          req_pop;
    logic          res_push;
    logic          res_full;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (sca_pkg::cfg_idx_t'(cfg_index))
                sca_pkg::CFG_CHANNELS_IN_USE: cfg_next.channels_in_use = cfg_data;
                sca_pkg::CFG_SOUND_ENABLED:   cfg_next.sound_enabled   = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channels_in_use <= sca_pkg::CHANNELS_RESET;
            cfg_reg.sound_enabled   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sca_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .sound_id       (sound_id),
        .sound_priority (sound_priority),
        .source_valid   (source_valid),
        .source_ref     (source_ref),
        .sector_valid   (sector_valid),
        .sector_num     (sector_num),
        .channel_sel    (channel_sel),
        .sound_enabled  (cfg_reg.sound_enabled),
        .req_valid      (req_valid),
        .req            (req),
        .req_pop        (req_pop)
    );

    sca_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    sca_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign event_res   = res_out.ev;
    assign channel_out = res_out.chan;
    assign last        = res_out.last;

endmodule

[bench/sound_channel_allocator_checker.sv]
// Checker for the sound channel allocator: voice table prediction and result beat compare.
`timescale 1ns / 1ps

module sound_channel_allocator_checker
    import sca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  cmd,
    input  logic [7:0]  sound_id,
    input  logic [7:0]  sound_priority,
    input  logic        source_valid,
    input  logic [15:0] source_ref,
    input  logic        sector_valid,
    input  logic [14:0] sector_num,
    input  logic [2:0]  channel_sel,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  event_res,
    input  logic [2:0]  channel_out,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    output int          error_count,
    output int          pending,
    output int          request_count,
    output int          beat_count,
    output int          grant_count,
    output int          refusal_count
);

    localparam int CHANNELS = 8;

    // Predicted voice table and register copies
    logic [7:0]  voice_sound  [CHANNELS];
    logic [7:0]  voice_prio   [CHANNELS];
    logic [15:0] voice_src    [CHANNELS];
    logic        voice_sec_on [CHANNELS];
    logic [14:0] voice_sec    [CHANNELS];
    logic [3:0]  live_channels;
    logic        fx_enabled;

    // Result beats still owed by the block, oldest first
    res_t        due_beats [$];

    function automatic void add_beat(event_t ev, int ch, logic fin);
        res_t r;
        r.ev   = ev;
        r.chan = 3'(ch);
        r.last = fin;
        due_beats.push_back(r);
    endfunction

    function automatic int sector_match(logic [14:0] sec, int cnt);
        int i;
        for (i = 0; i < cnt; i++)
            if (voice_sound[i] != 8'd0 && voice_sec_on[i] && voice_sec[i] == sec)
                return i;
        return -1;
    endfunction

    function automatic int source_match(logic [15:0] src, int cnt);
        int i;
        for (i = 0; i < cnt; i++)
            if (voice_sound[i] != 8'd0 && voice_src[i] == src)
                return i;
        return -1;
    endfunction

    // Update the table for one request and queue the beats it owes
    function automatic void allocate_voice(cmd_t kind, logic [7:0] sid, logic [7:0] prio,
                                           logic srcv, logic [15:0] src, logic secv,
                                           logic [14:0] sec, logic [2:0] sel);
        int cnt;
        int hit;
        int i;
        logic own_src;
        // clamp the searched range to 1..CHANNELS
        if (live_channels == 4'd0)
            cnt = 1;
        else if (live_channels > CHANNELS)
            cnt = CHANNELS;
        else
            cnt = int'(live_channels);
        own_src = srcv && (src != NO_SOURCE);
        hit = -1;
        case (kind)
            CMD_START:
            begin
                if (!fx_enabled || sid == 8'd0)
                begin
                    add_beat(EV_NO_CHANNEL, 0, 1'b1);
                    return;
                end
                // stop the earlier sound of this sector, or else of this source
                if (secv)
                    hit = sector_match(sec, cnt);
                else if (own_src)
                    hit = source_match(src, cnt);
                if (hit >= 0)
                begin
                    voice_sound[hit] = 8'd0;
                    add_beat(EV_STOPPED, hit, 1'b0);
                end
                // take the first free channel or one still playing this source
                hit = -1;
                for (i = 0; i < cnt; i++)
                begin
                    if (voice_sound[i] == 8'd0)
                    begin
                        hit = i;
                        break;
                    end
                    if (own_src && voice_src[i] == src)
                    begin
                        voice_sound[i] = 8'd0;
                        add_beat(EV_STOPPED, i, 1'b0);
                        hit = i;
                        break;
                    end
                end
                // steal the first channel no more important than the new sound
                if (hit < 0)
                begin
                    for (i = 0; i < cnt; i++)
                    begin
                        if (voice_prio[i] >= prio)
                        begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0)
                    begin
                        add_beat(EV_NO_CHANNEL, 0, 1'b1);
                        return;
                    end
                    voice_sound[hit] = 8'd0;
                    add_beat(EV_STOPPED, hit, 1'b0);
                end
                voice_sound[hit]  = sid;
                voice_prio[hit]   = prio;
                voice_src[hit]    = own_src ? src : NO_SOURCE;
                voice_sec_on[hit] = secv;
                voice_sec[hit]    = secv ? sec : 15'd0;
                add_beat(EV_GRANTED, hit, 1'b1);
                return;
            end
            CMD_STOP_SRC:
                if (own_src)
                    hit = source_match(src, cnt);
            CMD_STOP_SEC:
                if (secv)
                    hit = sector_match(sec, cnt);
            default:
                if (int'(sel) < cnt && voice_sound[sel] != 8'd0)
                    hit = int'(sel);
        endcase
        if (hit >= 0)
        begin
            voice_sound[hit] = 8'd0;
            add_beat(EV_STOPPED, hit, 1'b1);
        end
        else
        begin
            add_beat(EV_DONE, 0, 1'b1);
        end
    endfunction

    // Sample all channels at the falling edge, where every signal is settled
    always @(negedge clk)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                voice_sound[i]  = 8'd0;
                voice_prio[i]   = 8'd0;
                voice_src[i]    = NO_SOURCE;
                voice_sec_on[i] = 1'b0;
                voice_sec[i]    = 15'd0;
            end
            live_channels = CHANNELS_RESET;
            fx_enabled    = 1'b1;
            due_beats.delete();
            error_count   = 0;
            request_count = 0;
            beat_count    = 0;
            grant_count   = 0;
            refusal_count = 0;
        end
        else
        begin
            // register write beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CHANNELS_IN_USE: live_channels = cfg_data;
                    CFG_SOUND_ENABLED:   fx_enabled    = cfg_data[0];
                    default:             ;
                endcase
            end
            // result beat: compare with the oldest owed beat
            if (pop && !empty)
            begin
                beat_count++;
                if (due_beats.size() == 0)
                begin
                    if (error_count < 10)
                        $display("[%0t] unexpected result beat: ev=%0d ch=%0d last=%0d",
                                 $realtime, event_res, channel_out, last);
                    error_count++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (event_res !== want.ev || channel_out !== want.chan
                        || last !== want.last)
                    begin
                        if (error_count < 10)
                        begin
                            $write("[%0t] result beat mismatch: expected ev=%0d ch=%0d last=%0d",
                                   $realtime, want.ev, want.chan, want.last);
                            $display(", got ev=%0d ch=%0d last=%0d",
                                     event_res, channel_out, last);
                        end
                        error_count++;
                    end
                    if (want.ev == EV_GRANTED)
                        grant_count++;
                    else if (want.ev == EV_NO_CHANNEL)
                        refusal_count++;
                end
            end
            // request beat
            if (push && !full)
            begin
                request_count++;
                allocate_voice(cmd_t'(cmd), sound_id, sound_priority, source_valid,
                               source_ref, sector_valid, sector_num, channel_sel);
            end
        end
        pending = due_beats.size();
    end

endmodule

[bench/sound_channel_allocator_top_tb.sv]
// Testbench top for the sound channel allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sound_channel_allocator_top_tb;
    import sca_pkg::*;

    localparam int PHASES         = 8;
    localparam int RAND_PER_PHASE = 43;
    localparam int SETTLE_CYCLES  = 16;
    localparam int CYCLE_LIMIT    = 400000;

    // Register plan per phase, phase 0 in the low nibble
    localparam logic [PHASES*4-1:0] CHAN_PLAN =
        {4'd8, 4'd5, 4'd1, 4'd3, 4'd3, 4'd15, 4'd0, 4'd8};
    localparam logic [PHASES*4-1:0] ENABLE_PLAN =
        {4'h1, 4'h1, 4'h5, 4'hE, 4'h1, 4'hF, 4'h1, 4'h1};

    typedef struct {
        cmd_t        kind;
        logic [7:0]  sid;
        logic [7:0]  prio;
        logic        srcv;
        logic [15:0] src;
        logic        secv;
        logic [14:0] sec;
        logic [2:0]  sel;
    } sound_req_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  cmd;
    logic [7:0]  sound_id;
    logic [7:0]  sound_priority;
    logic        source_valid;
    logic [15:0] source_ref;
    logic        sector_valid;
    logic [14:0] sector_num;
    logic [2:0]  channel_sel;
    logic        empty;
    logic        pop;
    logic [1:0]  event_res;
    logic [2:0]  channel_out;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [3:0]  cfg_data;

    int          error_count;
    int          pending;
    int          request_count;
    int          beat_count;
    int          grant_count;
    int          refusal_count;

    int          cycle_count = 0;
    int          burst_left  = 0;
    int          gap_len     = 0;
    int          rx_mode     = 0;
    int          rx_left     = 0;
    int          rx_tick     = 0;

    sound_channel_allocator_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .sound_id       (sound_id),
        .sound_priority (sound_priority),
        .source_valid   (source_valid),
        .source_ref     (source_ref),
        .sector_valid   (sector_valid),
        .sector_num     (sector_num),
        .channel_sel    (channel_sel),
        .empty          (empty),
        .pop            (pop),
        .event_res      (event_res),
        .channel_out    (channel_out),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    sound_channel_allocator_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .sound_id       (sound_id),
        .sound_priority (sound_priority),
        .source_valid   (source_valid),
        .source_ref     (source_ref),
        .sector_valid   (sector_valid),
        .sector_num     (sector_num),
        .channel_sel    (channel_sel),
        .empty          (empty),
        .pop            (pop),
        .event_res      (event_res),
        .channel_out    (channel_out),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .error_count    (error_count),
        .pending        (pending),
        .request_count  (request_count),
        .beat_count     (beat_count),
        .grant_count    (grant_count),
        .refusal_count  (refusal_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter: end a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sound_channel_allocator_top_tb: done, errors");
        $finish;
    end

    // Result side: stall on modes that are picked at random and change over the run
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= (rx_tick % 4 == 0);
                2:       pop <= ($urandom_range(0, 1) == 1);
                default: pop <= (rx_tick % 16 >= 12);
            endcase
        end
    end

    function automatic sound_req_t req_of(cmd_t k, int sid, int prio, bit srcv, int src,
                                          bit secv, int sec, int sel);
        sound_req_t r;
        r.kind = k;
        r.sid  = 8'(sid);
        r.prio = 8'(prio);
        r.srcv = srcv;
        r.src  = 16'(src);
        r.secv = secv;
        r.sec  = 15'(sec);
        r.sel  = 3'(sel);
        return r;
    endfunction

    // Mostly starts on a small pool of sources and sectors so they collide
    function automatic sound_req_t rand_req();
        sound_req_t r;
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            r.kind = CMD_START;
        else if (k < 72)
            r.kind = CMD_STOP_SRC;
        else if (k < 82)
            r.kind = CMD_STOP_SEC;
        else
            r.kind = CMD_FREE;
        r.sid = ($urandom_range(0, 24) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        case ($urandom_range(0, 5))
            0:       r.prio = 8'd0;
            1:       r.prio = 8'd255;
            2:       r.prio = 8'($urandom_range(0, 3));
            default: r.prio = 8'($urandom_range(0, 255));
        endcase
        r.srcv = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 9))
            0:       r.src = NO_SOURCE;
            1:       r.src = 16'($urandom_range(0, 65535));
            2:       r.src = 16'hFFFE;
            default: r.src = 16'($urandom_range(0, 5));
        endcase
        r.secv = ($urandom_range(0, 2) == 0);
        r.sec  = ($urandom_range(0, 5) == 0) ? 15'($urandom_range(0, 32767))
                                              : 15'($urandom_range(0, 3));
        r.sel  = 3'($urandom_range(0, 7));
        return r;
    endfunction

    // Present one request, hold it until accepted, then pace the next burst
    task automatic offer(input sound_req_t r);
        logic took;
        took           = 1'b0;
        push           <= 1'b1;
        cmd            <= r.kind;
        sound_id       <= r.sid;
        sound_priority <= r.prio;
        source_valid   <= r.srcv;
        source_ref     <= r.src;
        sector_valid   <= r.secv;
        sector_num     <= r.sec;
        channel_sel    <= r.sel;
        while (!took)
        begin
            @(negedge clk);
            took = !full;
            @(posedge clk);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            if (gap_len > 0)
            begin
                push <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
    endtask

    // Hold one register write until the channel takes it
    task automatic write_reg(input cfg_idx_t idx, input logic [3:0] data);
        logic took;
        took      = 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        while (!took)
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
    endtask

    // Stimulus
    initial
    begin
        int phase;
        int i;
        rst_n          = 1'b0;
        push           = 1'b0;
        cmd            = CMD_START;
        sound_id       = 8'd0;
        sound_priority = 8'd0;
        source_valid   = 1'b0;
        source_ref     = 16'd0;
        sector_valid   = 1'b0;
        sector_num     = 15'd0;
        channel_sel    = 3'd0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_CHANNELS_IN_USE;
        cfg_data       = 4'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // drain, let the sequencer go quiet, then reprogram
            push <= 1'b0;
            while (pending != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_reg(CFG_CHANNELS_IN_USE, CHAN_PLAN[phase*4 +: 4]);
            write_reg(CFG_SOUND_ENABLED, ENABLE_PLAN[phase*4 +: 4]);
            cfg_valid <= 1'b0;

            case (phase)
                0:
                begin
                    // refusals and stops that find nothing
                    offer(req_of(CMD_START, 0, 10, 1, 4, 0, 0, 0));
                    offer(req_of(CMD_FREE, 0, 0, 0, 0, 0, 0, 3));
                    offer(req_of(CMD_STOP_SRC, 0, 0, 0, 5, 0, 0, 0));
                    offer(req_of(CMD_STOP_SRC, 0, 0, 1, 'hFFFF, 0, 0, 0));
                    offer(req_of(CMD_STOP_SEC, 0, 0, 0, 0, 0, 0, 0));
                    // fill all eight channels; channel 5 names the reserved source
                    for (i = 0; i < 8; i++)
                        offer(req_of(CMD_START, i + 1, (i == 7) ? 255 : 20 * i, 1,
                                     (i == 5) ? 'hFFFF : i, (i == 2 || i == 3),
                                     (i == 2) ? 'h7FFF : 0, 0));
                    // same source restarts, same sector restarts, steals
                    offer(req_of(CMD_START, 9, 50, 1, 1, 0, 0, 0));
                    offer(req_of(CMD_START, 10, 30, 1, 9, 1, 'h7FFF, 0));
                    offer(req_of(CMD_START, 11, 70, 0, 0, 0, 0, 0));
                    offer(req_of(CMD_START, 12, 255, 0, 0, 0, 0, 0));
                    // stops by source, by a stale sector, by a live sector, by channel
                    offer(req_of(CMD_STOP_SRC, 0, 0, 1, 3, 0, 0, 0));
                    offer(req_of(CMD_STOP_SEC, 0, 0, 0, 0, 1, 0, 0));
                    offer(req_of(CMD_STOP_SEC, 0, 0, 0, 0, 1, 'h7FFF, 0));
                    offer(req_of(CMD_FREE, 0, 0, 0, 0, 0, 0, 0));
                    offer(req_of(CMD_FREE, 0, 0, 0, 0, 0, 0, 0));
                    offer(req_of(CMD_START, 255, 128, 1, 'hFFFE, 1, 'h1234, 7));
                    offer(req_of(CMD_START, 200, 60, 1, 'hFFFE, 0, 0, 0));
                end
                1:
                begin
                    // one channel: take it, fail to steal it, free beyond the count
                    offer(req_of(CMD_START, 3, 0, 0, 0, 0, 0, 0));
                    offer(req_of(CMD_START, 5, 1, 0, 0, 0, 0, 0));
                    offer(req_of(CMD_FREE, 0, 0, 0, 0, 0, 0, 1));
                end
                4:
                begin
                    // effects off: a valid start is still refused
                    offer(req_of(CMD_START, 7, 0, 1, 2, 0, 0, 0));
                end
                default: ;
            endcase

            repeat (RAND_PER_PHASE) offer(rand_req());
        end

        // drain the last results
        push <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d result beats: %0d grants, %0d refused or unplaced",
                 request_count, beat_count, grant_count, refusal_count);
        $display("channel counts 0, 1, 3, 5, 8 and 15 over %0d register settings, effects on and off",
                 PHASES);
        if (error_count == 0 && pending == 0)
            $display("sound_channel_allocator_top_tb: done, clean");
        else
            $display("sound_channel_allocator_top_tb: done, errors");
        $finish;
    end

endmodule
